### design/detection_box_decode_macros.svh
// Assertion macros used by the detection box decoder checker
`ifndef DETECTION_BOX_DECODE_MACROS_SVH
`define DETECTION_BOX_DECODE_MACROS_SVH

// same-cycle implication
`define DBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/dbd_pkg.sv
// Types and constants of the detection box decoder
`default_nettype none
package dbd_pkg;

   localparam int COORD_W = 18;
   localparam int SCORE_W = 16;
   localparam int DIM_W = 13;
   localparam int POS_W = 12;
   localparam int CLASS_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DIFF_W = COORD_W + 1;
   localparam int START_PROD_W = DIFF_W + DIM_W;
   localparam int SIZE_PROD_W = COORD_W + DIM_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(4096);
   localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET = DIM_W'(640);
   localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = DIM_W'(640);
   localparam logic [SCORE_W-1:0] THRESHOLD_RESET = SCORE_W'(32768);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_SCORE_THRESHOLD
   } dbd_csr_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic [CLASS_W-1:0] class_index;
      logic [SCORE_W-1:0] score;
   } dbd_job_type;

   typedef struct packed {
      logic valid;
      dbd_job_type job;
   } dbd_beat_type;

endpackage
`default_nettype wire

### design/detection_box_decode.sv
// Detection box decoder top level: config registers, front end, queue, back end
// A passing box's last-class beat is written to the queue, then registered in s1 and out.
// Throughput: one req beat per cycle; req_ready drops only while the 4-entry queue is full.
// The back end drains one detection per cycle when not stalled by rsp_ready; two stages.
// Reset (synchronous, high) empties queue and pipeline, zeroes argmax state and held box,
// and loads image size 640 x 640 and score threshold 32768.
`default_nettype none
module detection_box_decode import dbd_pkg::*; #(
   parameter int MAX_CLASSES = 128,
   parameter int COORD_FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [COORD_W-1:0] req_center_x,
   input  wire logic [COORD_W-1:0] req_center_y,
   input  wire logic [COORD_W-1:0] req_box_w,
   input  wire logic [COORD_W-1:0] req_box_h,
   input  wire logic [SCORE_W-1:0] req_class_score,
   input  wire logic req_first_class,
   input  wire logic req_last_class,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [POS_W-1:0] rsp_box_left,
   output logic [POS_W-1:0] rsp_box_top,
   output logic [DIM_W-1:0] rsp_box_width,
   output logic [DIM_W-1:0] rsp_box_height,
   output logic [CLASS_W-1:0] rsp_class_index,
   output logic [SCORE_W-1:0] rsp_confidence,
   input  wire logic csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [DIM_W-1:0] image_width_ff, image_width_in;
   logic [DIM_W-1:0] image_height_ff, image_height_in;
   logic [SCORE_W-1:0] threshold_ff, threshold_in;
   dbd_beat_type push;
   dbd_beat_type head;
   logic pop;
   logic has_space;

   always_comb begin
      image_width_in = image_width_ff;
      image_height_in = image_height_ff;
      threshold_in = threshold_ff;
      if (csr_write_enable) begin
         case (dbd_csr_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               image_width_in = csr_write_data[DIM_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_in = csr_write_data[DIM_W-1:0];
            end
            CSR_SCORE_THRESHOLD: begin
               threshold_in = csr_write_data[SCORE_W-1:0];
            end
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         image_width_ff <= image_width_in;
         image_height_ff <= image_height_in;
         threshold_ff <= threshold_in;
      end
   end

   assign req_ready = has_space;

   dbd_front #(
      .MAX_CLASSES(MAX_CLASSES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(req_valid && has_space),
      .center_x(req_center_x),
      .center_y(req_center_y),
      .box_w(req_box_w),
      .box_h(req_box_h),
      .class_score(req_class_score),
      .first_class(req_first_class),
      .last_class(req_last_class),
      .score_threshold(threshold_ff),
      .push(push)
   );

   dbd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .pop(pop),
      .has_space(has_space),
      .head(head)
   );

   dbd_back #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .pop(pop),
      .image_width(image_width_ff),
      .image_height(image_height_ff),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_box_left(rsp_box_left),
      .rsp_box_top(rsp_box_top),
      .rsp_box_width(rsp_box_width),
      .rsp_box_height(rsp_box_height),
      .rsp_class_index(rsp_class_index),
      .rsp_confidence(rsp_confidence)
   );

endmodule
`default_nettype wire

### design/dbd_front.sv
// Front end: holds box coordinates, runs the class argmax and the threshold test
`default_nettype none
module dbd_front import dbd_pkg::*; #(
   parameter int MAX_CLASSES = 128
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic accept,
   input  wire logic [COORD_W-1:0] center_x,
   input  wire logic [COORD_W-1:0] center_y,
   input  wire logic [COORD_W-1:0] box_w,
   input  wire logic [COORD_W-1:0] box_h,
   input  wire logic [SCORE_W-1:0] class_score,
   input  wire logic first_class,
   input  wire logic last_class,
   input  wire logic [SCORE_W-1:0] score_threshold,
   output dbd_beat_type push
);

   localparam int CNT_W = $clog2(MAX_CLASSES + 1);

   logic [COORD_W-1:0] held_x_ff, held_x_in;
   logic [COORD_W-1:0] held_y_ff, held_y_in;
   logic [COORD_W-1:0] held_w_ff, held_w_in;
   logic [COORD_W-1:0] held_h_ff, held_h_in;
   logic [SCORE_W-1:0] best_score_ff, best_score_in;
   logic [CLASS_W-1:0] best_index_ff, best_index_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] count_eff;
   logic [SCORE_W-1:0] best_new;
   logic [CLASS_W-1:0] index_new;
   logic take_new;

   always_comb begin
      count_eff = first_class ? '0 : count_ff;
      take_new = (count_eff < CNT_W'(MAX_CLASSES)) &&
                 ((count_eff == '0) || (class_score > best_score_ff));
      best_new = take_new ? class_score : best_score_ff;
      index_new = take_new ? CLASS_W'(count_eff) : best_index_ff;

      held_x_in = held_x_ff;
      held_y_in = held_y_ff;
      held_w_in = held_w_ff;
      held_h_in = held_h_ff;
      best_score_in = best_score_ff;
      best_index_in = best_index_ff;
      count_in = count_ff;
      if (accept) begin
         if (first_class) begin
            held_x_in = center_x;
            held_y_in = center_y;
            held_w_in = box_w;
            held_h_in = box_h;
         end
         best_score_in = best_new;
         best_index_in = index_new;
         if (last_class) begin
            count_in = '0;
         end else if (count_eff < CNT_W'(MAX_CLASSES)) begin
            count_in = count_eff + CNT_W'(1);
         end else begin
            count_in = count_eff;
         end
      end

      push.valid = accept && last_class && (best_new >= score_threshold);
      push.job.x = held_x_in;
      push.job.y = held_y_in;
      push.job.w = held_w_in;
      push.job.h = held_h_in;
      push.job.class_index = index_new;
      push.job.score = best_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
         held_y_ff <= '0;
         held_w_ff <= '0;
         held_h_ff <= '0;
         best_score_ff <= '0;
         best_index_ff <= '0;
         count_ff <= '0;
      end else begin
         held_x_ff <= held_x_in;
         held_y_ff <= held_y_in;
         held_w_ff <= held_w_in;
         held_h_ff <= held_h_in;
         best_score_ff <= best_score_in;
         best_index_ff <= best_index_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

### design/dbd_queue.sv
// Detection queue between the argmax front end and the scaling back end
`default_nettype none
module dbd_queue import dbd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire dbd_beat_type push,
   input  wire logic pop,
   output logic has_space,
   output dbd_beat_type head
);

   dbd_job_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic do_pop;

   always_comb begin
      has_space = count_ff != QCNT_W'(QUEUE_DEPTH);
      head.valid = count_ff != '0;
      head.job = entry_ff[rd_ptr_ff];
      do_pop = pop && head.valid;
      wr_ptr_in = push.valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + QCNT_W'(push.valid) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

### design/dbd_back.sv
// Back end: scales a detection to pixels and clamps it to the image, two stages
`default_nettype none
module dbd_back import dbd_pkg::*; #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire dbd_beat_type head,
   output logic pop,
   input  wire logic [DIM_W-1:0] image_width,
   input  wire logic [DIM_W-1:0] image_height,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [POS_W-1:0] rsp_box_left,
   output logic [POS_W-1:0] rsp_box_top,
   output logic [DIM_W-1:0] rsp_box_width,
   output logic [DIM_W-1:0] rsp_box_height,
   output logic [CLASS_W-1:0] rsp_class_index,
   output logic [SCORE_W-1:0] rsp_confidence
);

   function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] r);
      sat_dim = (r > DIM_MAX) ? DIM_MAX : r;
   endfunction

   function automatic logic [START_PROD_W-1:0] start_prod(
      input logic [COORD_W-1:0] c,
      input logic [COORD_W-1:0] s,
      input logic [DIM_W-1:0] dim
   );
      logic [DIFF_W-1:0] twice_c;
      logic [DIFF_W-1:0] diff;
      twice_c = {c, 1'b0};
      diff = twice_c - DIFF_W'(s);
      start_prod = (twice_c < DIFF_W'(s)) ? '0 :
                   START_PROD_W'(diff) * START_PROD_W'(dim);
   endfunction

   function automatic logic [POS_W+DIM_W-1:0] finish_axis(
      input logic [START_PROD_W-1:0] p,
      input logic [SIZE_PROD_W-1:0] q,
      input logic [DIM_W-1:0] dim
   );
      logic [START_PROD_W-1:0] lo_raw;
      logic [SIZE_PROD_W-1:0] sz_raw;
      logic [DIM_W-1:0] lo;
      logic [DIM_W-1:0] room;
      logic [DIM_W-1:0] sz;
      lo_raw = p >> (COORD_FRAC_BITS + 1);
      sz_raw = q >> COORD_FRAC_BITS;
      if (dim == '0) begin
         lo = '0;
      end else if (lo_raw > START_PROD_W'(dim - DIM_W'(1))) begin
         lo = dim - DIM_W'(1);
      end else begin
         lo = DIM_W'(lo_raw);
      end
      room = dim - lo;
      sz = (sz_raw > SIZE_PROD_W'(room)) ? room : DIM_W'(sz_raw);
      if (sz == '0) begin
         sz = DIM_W'(1);
      end
      finish_axis = {POS_W'(lo), sz};
   endfunction

   logic s1_valid_ff, s1_valid_in;
   logic [START_PROD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [SIZE_PROD_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [DIM_W-1:0] dim_x_ff, dim_x_in, dim_y_ff, dim_y_in;
   logic [CLASS_W-1:0] s1_class_ff, s1_class_in;
   logic [SCORE_W-1:0] s1_score_ff, s1_score_in;

   logic out_valid_ff, out_valid_in;
   logic [POS_W+DIM_W-1:0] axis_x_ff, axis_x_in, axis_y_ff, axis_y_in;
   logic [CLASS_W-1:0] out_class_ff, out_class_in;
   logic [SCORE_W-1:0] out_score_ff, out_score_in;

   logic out_adv;
   logic s1_adv;
   logic [DIM_W-1:0] dim_x;
   logic [DIM_W-1:0] dim_y;

   always_comb begin
      out_adv = !out_valid_ff || rsp_ready;
      s1_adv = !s1_valid_ff || out_adv;
      pop = head.valid && s1_adv;
      dim_x = sat_dim(image_width);
      dim_y = sat_dim(image_height);

      s1_valid_in = s1_adv ? head.valid : s1_valid_ff;
      px_in = px_ff;
      py_in = py_ff;
      qx_in = qx_ff;
      qy_in = qy_ff;
      dim_x_in = dim_x_ff;
      dim_y_in = dim_y_ff;
      s1_class_in = s1_class_ff;
      s1_score_in = s1_score_ff;
      if (pop) begin
         px_in = start_prod(head.job.x, head.job.w, dim_x);
         py_in = start_prod(head.job.y, head.job.h, dim_y);
         qx_in = SIZE_PROD_W'(head.job.w) * SIZE_PROD_W'(dim_x);
         qy_in = SIZE_PROD_W'(head.job.h) * SIZE_PROD_W'(dim_y);
         dim_x_in = dim_x;
         dim_y_in = dim_y;
         s1_class_in = head.job.class_index;
         s1_score_in = head.job.score;
      end

      out_valid_in = out_adv ? s1_valid_ff : out_valid_ff;
      axis_x_in = axis_x_ff;
      axis_y_in = axis_y_ff;
      out_class_in = out_class_ff;
      out_score_in = out_score_ff;
      if (out_adv && s1_valid_ff) begin
         axis_x_in = finish_axis(px_ff, qx_ff, dim_x_ff);
         axis_y_in = finish_axis(py_ff, qy_ff, dim_y_ff);
         out_class_in = s1_class_ff;
         out_score_in = s1_score_ff;
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      qx_ff <= qx_in;
      qy_ff <= qy_in;
      dim_x_ff <= dim_x_in;
      dim_y_ff <= dim_y_in;
      s1_class_ff <= s1_class_in;
      s1_score_ff <= s1_score_in;
      axis_x_ff <= axis_x_in;
      axis_y_ff <= axis_y_in;
      out_class_ff <= out_class_in;
      out_score_ff <= out_score_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_box_left = axis_x_ff[POS_W+DIM_W-1:DIM_W];
   assign rsp_box_width = axis_x_ff[DIM_W-1:0];
   assign rsp_box_top = axis_y_ff[POS_W+DIM_W-1:DIM_W];
   assign rsp_box_height = axis_y_ff[DIM_W-1:0];
   assign rsp_class_index = out_class_ff;
   assign rsp_confidence = out_score_ff;

endmodule
`default_nettype wire

### design/dbd_checker.sv
// Port-level checker for the detection box decoder and its bind
`default_nettype none
`include "detection_box_decode_macros.svh"
module dbd_checker import dbd_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [POS_W-1:0] rsp_box_left,
   input wire logic [POS_W-1:0] rsp_box_top,
   input wire logic [DIM_W-1:0] rsp_box_width,
   input wire logic [DIM_W-1:0] rsp_box_height,
   input wire logic [CLASS_W-1:0] rsp_class_index,
   input wire logic [SCORE_W-1:0] rsp_confidence
);

   localparam int END_W = DIM_W + 1;
   localparam int BEAT_W = 2 * POS_W + 2 * DIM_W + CLASS_W + SCORE_W;

   logic [BEAT_W-1:0] rsp_beat;
   logic rsp_stall;
   logic size_ok;
   logic [END_W-1:0] x_end;
   logic [END_W-1:0] y_end;
   logic frame_ok;

   assign rsp_beat = {rsp_box_left, rsp_box_top, rsp_box_width, rsp_box_height,
                      rsp_class_index, rsp_confidence};
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign size_ok = (rsp_box_width != '0) && (rsp_box_height != '0);
   assign x_end = END_W'(rsp_box_left) + END_W'(rsp_box_width);
   assign y_end = END_W'(rsp_box_top) + END_W'(rsp_box_height);
   assign frame_ok = (x_end <= END_W'(DIM_MAX)) && (y_end <= END_W'(DIM_MAX));

   `DBD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_beat), "stall change")
   `DBD_ASSERT_NOW(a_size_nonzero, clock, reset, rsp_valid, size_ok, "zero box size")
   `DBD_ASSERT_NOW(a_inside_frame, clock, reset, rsp_valid, frame_ok, "box leaves frame")
   `DBD_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "rsp beat right after reset")

endmodule

bind detection_box_decode dbd_checker u_dbd_checker (.*);
`default_nettype wire
